@@ src/rfft_pkg.sv @@
// Package for the in-place real FFT: constants, types and the twiddle ROM function.
package rfft_pkg;

	localparam int MAX_POINTS   = 1024;
	localparam int SAMPLE_BITS  = 16;
	localparam int TWIDDLE_BITS = 16;
	localparam int ADDR_BITS    = $clog2(MAX_POINTS);
	localparam int CNT_BITS     = ADDR_BITS + 1;
	localparam int WORD_BITS    = 32;
	localparam int LOG_BITS     = 4;
	localparam int QUARTER      = MAX_POINTS / 4;
	// twiddle indices stay in 1..QUARTER-1, so the table stops short of a quarter wave
	localparam int ROM_DEPTH    = QUARTER;
	localparam int ROM_ABITS    = $clog2(ROM_DEPTH);
	localparam int TW_FRAC      = TWIDDLE_BITS - 1;
	localparam int PROD_BITS    = WORD_BITS + TWIDDLE_BITS + 1;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_BITS-1:0]        addr_t;
	typedef logic [TWIDDLE_BITS-1:0]     tw_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REV_RD,  ST_REV_RD2, ST_REV_W1, ST_REV_W2,
		ST_B2_RD,   ST_B2_RD2,  ST_B2_W1,  ST_B2_W2,
		ST_G_RD,    ST_G_RD2,   ST_G_W1,   ST_G_W2,
		ST_Q_RD,    ST_Q_W,
		ST_J_RD1,   ST_J_RD2,
		ST_J_MUL,   ST_J_SUM,   ST_J_W1,  ST_J_W2, ST_J_W3, ST_J_W4,
		ST_NEXT
	} seq_state_t;

	// Status from the sequencer to the top level
	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

	function automatic word_t sat32(input logic signed [WORD_BITS+1:0] v);
		if (v > $signed({{2{1'b0}}, 1'b0, {(WORD_BITS-1){1'b1}}}))
			return {1'b0, {(WORD_BITS-1){1'b1}}};
		if (v < $signed({{2{1'b1}}, 1'b1, {(WORD_BITS-1){1'b0}}}))
			return {1'b1, {(WORD_BITS-1){1'b0}}};
		return v[WORD_BITS-1:0];
	endfunction

	// Restoring long division, used only while building the table
	function automatic logic [127:0] udiv128(input logic [127:0] num, input logic [127:0] den);
		logic [127:0] q, rem;
		q   = '0;
		rem = '0;
		for (int b = 127; b >= 0; b--) begin
			rem = {rem[126:0], num[b]};
			if (rem >= den) begin
				rem  = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Quarter-wave cosine entry (elaborated into a constant table)
	function automatic tw_t rom_entry(input int t);
		logic [127:0] th, x2, term, one;
		longint sum, r, top;
		int sh;
		one  = 128'd1073741824;
		th   = (128'd3373259426 * 2 * t + (MAX_POINTS >> 1)) >> ADDR_BITS;
		x2   = (th * th + (128'd1 << 29)) >> 30;
		term = one;
		sum  = 1073741824;
		for (int i = 1; i <= 10; i++) begin
			term = (term * x2 + (128'd1 << 29)) >> 30;
			term = udiv128(term, 128'((2 * i) * (2 * i - 1)));
			if ((i & 1) == 1) sum = sum - longint'(term[63:0]);
			else sum = sum + longint'(term[63:0]);
		end
		if (sum < 0) sum = 0;
		if (sum > 1073741824) sum = 1073741824;
		sh  = 31 - TWIDDLE_BITS;
		r   = (sum + (longint'(1) << (sh - 1))) >>> sh;
		top = (longint'(1) << (TWIDDLE_BITS - 1)) - 1;
		if (r > top) r = top;
		return r[TWIDDLE_BITS-1:0];
	endfunction

	typedef tw_t rom_arr_t [ROM_DEPTH];

	function automatic rom_arr_t rom_build();
		rom_arr_t a;
		for (int t = 0; t < ROM_DEPTH; t++) a[t] = rom_entry(t);
		return a;
	endfunction

	localparam rom_arr_t TW_ROM = rom_build();

endpackage

@@ src/rfft_ram.sv @@
// Generic single-port RAM with registered read.
module rfft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

@@ src/rfft_seq.sv @@
// Transform sequencer: reorder, length-2 and staged butterflies over the word store.
module rfft_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rfft_pkg::LOG_BITS-1:0] m,
	input  rfft_pkg::word_t               rdata,
	output logic                          we,
	output rfft_pkg::addr_t               addr,
	output rfft_pkg::word_t               wdata,
	output rfft_pkg::seq_stat_t           stat
);
	localparam int AB = rfft_pkg::ADDR_BITS;
	localparam int CB = rfft_pkg::CNT_BITS;
	localparam int PB = rfft_pkg::PROD_BITS;
	localparam logic signed [PB-1:0] RND = PB'(1) << (rfft_pkg::TW_FRAC - 1);

	rfft_pkg::seq_state_t state_q, state_d;
	logic [CB-1:0] i_q, i_d, j_q, j_d, n2_q, n2_d;
	logic [rfft_pkg::LOG_BITS-1:0] k_q, k_d;
	rfft_pkg::word_t a_q, b_q, c_q, a_d, b_d, c_d;
	rfft_pkg::word_t t1_q, t2_q, t1_d, t2_d;
	logic signed [PB-1:0] p_q [4];
	logic signed [PB-1:0] p_d [4];
	logic [CB-1:0] n, n4, n1, rev, i1, i2, i3, i4;
	logic [CB-1:0] tix;
	logic [rfft_pkg::ROM_ABITS-1:0] cidx, sidx;
	logic [rfft_pkg::ROM_ABITS:0] sfull;
	logic signed [rfft_pkg::TWIDDLE_BITS:0] cc, ss;
	logic done_q, done_d;

	// product rounded half up and scaled back to word range
	function automatic logic signed [rfft_pkg::WORD_BITS+1:0] tm(
		input logic signed [PB-1:0] p);
		logic signed [PB-1:0] r;
		r = (p + RND) >>> rfft_pkg::TW_FRAC;
		return r[rfft_pkg::WORD_BITS+1:0];
	endfunction

	function automatic logic signed [rfft_pkg::WORD_BITS+1:0] ex(input rfft_pkg::word_t v);
		return {{2{v[rfft_pkg::WORD_BITS-1]}}, v};
	endfunction

	// Index arithmetic
	always_comb begin
		n   = CB'(1) << m;
		n4  = n2_q >> 1;
		n1  = n2_q << 1;
		rev = '0;
		for (int b = 0; b < AB; b++)
			if (b < int'(m) && i_q[b]) rev = rev | (CB'(1) << (int'(m) - 1 - b));
		i1  = i_q + j_q;
		i2  = i_q - j_q + n2_q;
		i3  = i_q + j_q + n2_q;
		i4  = i_q - j_q + n1;
		// twiddle step: j * MAX_POINTS / 2^k
		tix   = j_q << (AB - int'(k_q));
		cidx  = rfft_pkg::ROM_ABITS'(tix);
		sfull = (rfft_pkg::ROM_ABITS + 1)'(rfft_pkg::QUARTER) - {1'b0, cidx};
		sidx  = sfull[rfft_pkg::ROM_ABITS-1:0];
		cc    = $signed({1'b0, rfft_pkg::TW_ROM[cidx]});
		ss    = $signed({1'b0, rfft_pkg::TW_ROM[sidx]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfft_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d; j_q <= j_d; n2_q <= n2_d; k_q <= k_d;
		a_q <= a_d; b_q <= b_d; c_q <= c_d;
		t1_q <= t1_d; t2_q <= t2_d;
		for (int q = 0; q < 4; q++) p_q[q] <= p_d[q];
	end

	// Next state and memory port
	always_comb begin
		state_d = state_q;
		done_d = 1'b0;
		i_d = i_q; j_d = j_q; n2_d = n2_q; k_d = k_q;
		a_d = a_q; b_d = b_q; c_d = c_q;
		t1_d = t1_q; t2_d = t2_q;
		for (int q = 0; q < 4; q++) p_d[q] = p_q[q];
		we = 1'b0; addr = AB'(i_q); wdata = a_q;
		case (state_q)
			rfft_pkg::ST_IDLE: begin
				if (start) begin
					i_d = '0;
					state_d = rfft_pkg::ST_REV_RD;
				end
			end
			// bit-reversal swap
			rfft_pkg::ST_REV_RD: begin
				if (i_q >= n) begin
					i_d = '0;
					state_d = rfft_pkg::ST_B2_RD;
				end else if (i_q < rev) begin
					addr = AB'(i_q);
					state_d = rfft_pkg::ST_REV_RD2;
				end else i_d = i_q + 1'b1;
			end
			rfft_pkg::ST_REV_RD2: begin
				addr = AB'(rev); a_d = rdata;
				state_d = rfft_pkg::ST_REV_W1;
			end
			rfft_pkg::ST_REV_W1: begin
				we = 1'b1; addr = AB'(i_q); wdata = rdata;
				state_d = rfft_pkg::ST_REV_W2;
			end
			rfft_pkg::ST_REV_W2: begin
				we = 1'b1; addr = AB'(rev); wdata = a_q;
				i_d = i_q + 1'b1;
				state_d = rfft_pkg::ST_REV_RD;
			end
			// length-2 butterflies
			rfft_pkg::ST_B2_RD: begin
				if (i_q >= n) begin
					n2_d = CB'(2); k_d = rfft_pkg::LOG_BITS'(2);
					state_d = (m >= 4'd2) ? rfft_pkg::ST_G_RD : rfft_pkg::ST_NEXT;
					i_d = '0;
				end else begin
					addr = AB'(i_q);
					state_d = rfft_pkg::ST_B2_RD2;
				end
			end
			rfft_pkg::ST_B2_RD2: begin
				addr = AB'(i_q + 1'b1); a_d = rdata;
				state_d = rfft_pkg::ST_B2_W1;
			end
			rfft_pkg::ST_B2_W1: begin
				we = 1'b1; addr = AB'(i_q);
				wdata = rfft_pkg::sat32(ex(a_q) + ex(rdata));
				b_d = rfft_pkg::sat32(ex(a_q) - ex(rdata));
				state_d = rfft_pkg::ST_B2_W2;
			end
			rfft_pkg::ST_B2_W2: begin
				we = 1'b1; addr = AB'(i_q + 1'b1); wdata = b_q;
				i_d = i_q + 2'd2;
				state_d = rfft_pkg::ST_B2_RD;
			end
			// group head: x[i], x[i+n2], x[i+n2+n4]
			rfft_pkg::ST_G_RD: begin
				if (i_q >= n) begin
					if (k_q >= m) state_d = rfft_pkg::ST_NEXT;
					else begin
						k_d = k_q + 1'b1; n2_d = n2_q << 1; i_d = '0;
					end
				end else begin
					addr = AB'(i_q);
					state_d = rfft_pkg::ST_G_RD2;
				end
			end
			rfft_pkg::ST_G_RD2: begin
				addr = AB'(i_q + n2_q); a_d = rdata;
				state_d = rfft_pkg::ST_G_W1;
			end
			rfft_pkg::ST_G_W1: begin
				we = 1'b1; addr = AB'(i_q);
				wdata = rfft_pkg::sat32(ex(a_q) + ex(rdata));
				b_d = rfft_pkg::sat32(ex(a_q) - ex(rdata));
				state_d = rfft_pkg::ST_G_W2;
			end
			rfft_pkg::ST_G_W2: begin
				we = 1'b1; addr = AB'(i_q + n2_q); wdata = b_q;
				state_d = rfft_pkg::ST_Q_RD;
			end
			// negate x[i+n2+n4]
			rfft_pkg::ST_Q_RD: begin
				addr = AB'(i_q + n2_q + n4);
				state_d = rfft_pkg::ST_Q_W;
			end
			rfft_pkg::ST_Q_W: begin
				we = 1'b1; addr = AB'(i_q + n2_q + n4);
				wdata = rfft_pkg::sat32(-ex(rdata));
				j_d = CB'(1);
				state_d = rfft_pkg::ST_J_RD1;
			end
			// twiddle butterflies for j = 1 .. n4-1
			rfft_pkg::ST_J_RD1: begin
				if (j_q >= n4) begin
					i_d = i_q + n1;
					state_d = rfft_pkg::ST_G_RD;
				end else begin
					addr = AB'(i3);
					state_d = rfft_pkg::ST_J_RD2;
				end
			end
			rfft_pkg::ST_J_RD2: begin
				addr = AB'(i4); c_d = rdata;
				state_d = rfft_pkg::ST_J_MUL;
			end
			rfft_pkg::ST_J_MUL: begin
				addr = AB'(i2);
				p_d[0] = cc * c_q; p_d[1] = ss * rdata;
				p_d[2] = ss * c_q; p_d[3] = cc * rdata;
				state_d = rfft_pkg::ST_J_SUM;
			end
			rfft_pkg::ST_J_SUM: begin
				a_d = rdata; addr = AB'(i1);
				t1_d = rfft_pkg::sat32(tm(p_q[0]) + tm(p_q[1]));
				t2_d = rfft_pkg::sat32(tm(p_q[2]) - tm(p_q[3]));
				state_d = rfft_pkg::ST_J_W1;
			end
			rfft_pkg::ST_J_W1: begin
				b_d = rdata; we = 1'b1; addr = AB'(i4);
				wdata = rfft_pkg::sat32(ex(a_q) - ex(t2_q));
				state_d = rfft_pkg::ST_J_W2;
			end
			rfft_pkg::ST_J_W2: begin
				we = 1'b1; addr = AB'(i3);
				wdata = rfft_pkg::sat32(-ex(a_q) - ex(t2_q));
				state_d = rfft_pkg::ST_J_W3;
			end
			rfft_pkg::ST_J_W3: begin
				we = 1'b1; addr = AB'(i2);
				wdata = rfft_pkg::sat32(ex(b_q) - ex(t1_q));
				state_d = rfft_pkg::ST_J_W4;
			end
			rfft_pkg::ST_J_W4: begin
				we = 1'b1; addr = AB'(i1);
				wdata = rfft_pkg::sat32(ex(b_q) + ex(t1_q));
				j_d = j_q + 1'b1;
				state_d = rfft_pkg::ST_J_RD1;
			end
			rfft_pkg::ST_NEXT: begin
				done_d = 1'b1;
				state_d = rfft_pkg::ST_IDLE;
			end
			default: state_d = rfft_pkg::ST_IDLE;
		endcase
	end

	assign stat.busy = (state_q != rfft_pkg::ST_IDLE);
	assign stat.done = done_q;
endmodule

@@ src/real_fft_in_place.sv @@
// Top level of the in-place real FFT: load, read and transform over one word store.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | kind, sample, word_index
//  out     | output    | out_valid / out_stall| value, result_index, last, ready_res
//  cfg     | input     | cfg_we               | cfg_data (size_log2)
//
// A load writes its sample at the load count; the n-th load starts the transform on the single RAM port:
// a reorder swap reads and writes both words, a length-2 pair reads and writes two,
// and each twiddle butterfly reads four words and writes four.
// A read is registered in rd_s1 and then held in the output register; the input is stalled behind it.
// Reset sets the size to 10 and clears the load count and the done flag, not the store.
// Input is stalled from the last load until the transform ends, behind a read, and while
// a held result is stalled.
module real_fft_in_place (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic signed [rfft_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [9:0]                           word_index,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [31:0]                   value,
	output logic [9:0]                           result_index,
	output logic                                 last,
	output logic                                 ready_res,
	input  logic                                 cfg_we,
	input  logic [rfft_pkg::LOG_BITS-1:0]        cfg_data
);
	localparam int AB = rfft_pkg::ADDR_BITS;
	localparam int CB = rfft_pkg::CNT_BITS;

	logic [rfft_pkg::LOG_BITS-1:0] size_q, m;
	logic [CB-1:0] cnt_q, n;
	logic done_q, rd_s1, rd_ok_s1, rdy_s1, out_full_q, acc;
	logic [9:0] idx_s1;
	logic last_s1;
	logic start_q;
	rfft_pkg::seq_stat_t stat;
	logic seq_we, ram_we;
	rfft_pkg::addr_t seq_addr, ram_addr;
	rfft_pkg::word_t seq_wdata, ram_wdata, rdata;

	// effective size
	always_comb begin
		m = size_q;
		if (m < 4'd1) m = 4'd1;
		if (m > rfft_pkg::LOG_BITS'(AB)) m = rfft_pkg::LOG_BITS'(AB);
		n = CB'(1) << m;
	end

	assign in_stall = stat.busy | stat.done | start_q | rd_s1 | (out_full_q & out_stall);
	assign acc = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 4'd10; cnt_q <= '0; done_q <= 1'b0;
			rd_s1 <= 1'b0; out_full_q <= 1'b0; start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (stat.done) done_q <= 1'b1;
			if (cfg_we) begin
				size_q <= cfg_data; cnt_q <= '0; done_q <= 1'b0;
			end else if (acc && !kind) begin
				if (cnt_q == '0 || cnt_q >= n) done_q <= 1'b0;
				if ((cnt_q >= n ? CB'(0) : cnt_q) + 1'b1 == n) begin
					cnt_q <= '0; start_q <= 1'b1;
				end else cnt_q <= (cnt_q >= n ? CB'(0) : cnt_q) + 1'b1;
			end
			rd_s1 <= acc & kind;
			if (rd_s1) out_full_q <= 1'b1;
			else if (!out_stall) out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_s1 <= word_index;
			last_s1 <= ({1'b0, word_index} == CB'(n - 1'b1));
			rd_ok_s1 <= done_q && ({1'b0, word_index} < n);
			rdy_s1 <= done_q;
		end
		if (rd_s1) begin
			value <= rd_ok_s1 ? rdata : '0;
			result_index <= idx_s1;
			last <= last_s1;
			ready_res <= rdy_s1;
		end
	end
	assign out_valid = out_full_q;

	// RAM port mux
	always_comb begin
		if (stat.busy) begin
			ram_we = seq_we; ram_addr = seq_addr; ram_wdata = seq_wdata;
		end else begin
			ram_we = acc & ~kind;
			ram_addr = kind ? AB'(word_index) : AB'(cnt_q >= n ? CB'(0) : cnt_q);
			ram_wdata = rfft_pkg::word_t'(sample);
		end
	end

	rfft_ram #(.WIDTH(rfft_pkg::WORD_BITS), .DEPTH(rfft_pkg::MAX_POINTS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rdata)
	);

	rfft_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(start_q), .m(m), .rdata(rdata),
		.we(seq_we), .addr(seq_addr), .wdata(seq_wdata), .stat(stat)
	);
endmodule

@@ tb/real_fft_in_place_tb.sv @@
// Testbench for real_fft_in_place: fixed-point predictor, directed and random tests.
module real_fft_in_place_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		rfft_pkg::word_t value;
		logic [9:0]      index;
		logic            last;
		logic            ready;
	} spectrum_word_t;

	logic clk, arst_n;
	logic in_valid, in_stall, kind;
	logic signed [rfft_pkg::SAMPLE_BITS-1:0] sample;
	logic [9:0] word_index;
	logic out_valid, out_stall;
	logic signed [31:0] value;
	logic [9:0] result_index;
	logic last, ready_res;
	logic cfg_we;
	logic [rfft_pkg::LOG_BITS-1:0] cfg_data;

	real_fft_in_place dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .sample(sample), .word_index(word_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .result_index(result_index), .last(last), .ready_res(ready_res),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Predictor state
	int            fft_words [rfft_pkg::MAX_POINTS];
	int            frame_fill;
	bit            spectrum_ready;
	logic [3:0]    size_reg;
	spectrum_word_t spectrum_q [$];

	int  errors;
	int  send_gap_pct, recv_gap_pct;
	int  hold_off_cycles;
	int  quiet_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int points_log2();
		if (size_reg < 1) return 1;
		if (size_reg > 10) return 10;
		return size_reg;
	endfunction

	function automatic int clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	// Q1.15 cosine from the integer Taylor series
	function automatic longint cos_q15(input int t);
		logic [127:0] th, x2, term;
		longint sum, r;
		th = (128'd3373259426 * 2 * t + 512) / 1024;
		x2 = (th * th + (128'd1 << 29)) >> 30;
		term = 128'd1073741824;
		sum = 1073741824;
		for (int i = 1; i <= 10; i++) begin
			term = (term * x2 + (128'd1 << 29)) >> 30;
			term = term / ((2 * i) * (2 * i - 1));
			if (i % 2) sum -= longint'(term[63:0]);
			else sum += longint'(term[63:0]);
		end
		if (sum < 0) sum = 0;
		if (sum > 1073741824) sum = 1073741824;
		r = (sum + 64'sd16384) >>> 15;
		return (r > 32767) ? 64'sd32767 : r;
	endfunction

	function automatic longint twiddle_mul(input longint c, input int x);
		return (c * longint'(x) + 64'sd16384) >>> 15;
	endfunction

	// In-place real-valued FFT over the predictor's word store
	task automatic run_real_fft(input int m);
		int n, r, tmp, a, c, n1, n2, n4, stp, i1, i2, i3, i4;
		longint cc, ss;
		int t1, t2;
		n = 1 << m;
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int b = 0; b < m; b++)
				if (i & (1 << b)) r |= 1 << (m - 1 - b);
			if (i < r) begin
				tmp = fft_words[i]; fft_words[i] = fft_words[r]; fft_words[r] = tmp;
			end
		end
		for (int i = 0; i < n; i += 2) begin
			a = fft_words[i]; c = fft_words[i+1];
			fft_words[i] = clamp32(longint'(a) + c);
			fft_words[i+1] = clamp32(longint'(a) - c);
		end
		n2 = 1;
		for (int k = 2; k <= m; k++) begin
			n4 = n2; n2 = 2 * n4; n1 = 2 * n2;
			stp = rfft_pkg::MAX_POINTS / n1;
			for (int i = 0; i < n; i += n1) begin
				a = fft_words[i];
				fft_words[i] = clamp32(longint'(a) + fft_words[i+n2]);
				fft_words[i+n2] = clamp32(longint'(a) - fft_words[i+n2]);
				fft_words[i+n2+n4] = clamp32(-longint'(fft_words[i+n2+n4]));
				for (int j = 1; j < n4; j++) begin
					i1 = i + j; i2 = i - j + n2; i3 = i + j + n2; i4 = i - j + n1;
					cc = cos_q15(j * stp);
					ss = cos_q15(rfft_pkg::MAX_POINTS / 4 - j * stp);
					t1 = clamp32(twiddle_mul(cc, fft_words[i3]) + twiddle_mul(ss, fft_words[i4]));
					t2 = clamp32(twiddle_mul(ss, fft_words[i3]) - twiddle_mul(cc, fft_words[i4]));
					fft_words[i4] = clamp32(longint'(fft_words[i2]) - t2);
					fft_words[i3] = clamp32(-longint'(fft_words[i2]) - t2);
					fft_words[i2] = clamp32(longint'(fft_words[i1]) - t1);
					fft_words[i1] = clamp32(longint'(fft_words[i1]) + t1);
				end
			end
		end
	endtask

	// Predict the effect of one accepted word
	task automatic predict_word(input logic k, input logic signed [15:0] s, input logic [9:0] idx);
		int m, n;
		spectrum_word_t e;
		m = points_log2();
		n = 1 << m;
		if (k == KIND_LOAD) begin
			if (frame_fill >= n) frame_fill = 0;
			if (frame_fill == 0) spectrum_ready = 0;
			fft_words[frame_fill] = int'(s);
			frame_fill++;
			if (frame_fill == n) begin
				run_real_fft(m);
				spectrum_ready = 1;
				frame_fill = 0;
			end
		end else begin
			e.value = (spectrum_ready && idx < n) ? rfft_pkg::word_t'(fft_words[idx]) : '0;
			e.index = idx;
			e.last = (idx == n - 1);
			e.ready = spectrum_ready;
			spectrum_q.push_back(e);
		end
	endtask

	// Offer one word, called at a falling edge; returns at a falling edge
	task automatic send_word(input logic k, input logic signed [15:0] s, input logic [9:0] idx);
		if ($urandom_range(99) < send_gap_pct) repeat ($urandom_range(1, 4)) @(negedge clk);
		in_valid = 1'b1; kind = k; sample = s; word_index = idx;
		do @(posedge clk); while (in_stall);
		predict_word(k, s, idx);
		@(negedge clk);
		in_valid = 1'b0;
		kind = $urandom; sample = $urandom; word_index = $urandom;
	endtask

	task automatic load_sample(input logic signed [15:0] s);
		send_word(KIND_LOAD, s, $urandom);
	endtask

	task automatic read_word(input int idx);
		send_word(KIND_READ, $urandom, idx[9:0]);
	endtask

	task automatic wait_drained();
		while (spectrum_q.size() != 0) @(negedge clk);
	endtask

	// Let a transform that gives no result finish before touching the register
	task automatic settle_and_set_size(input logic [3:0] sz);
		int m;
		wait_drained();
		m = points_log2();
		repeat (4 * (1 << m) * m + 50) @(negedge clk);
		cfg_we = 1'b1; cfg_data = sz;
		@(negedge clk);
		cfg_we = 1'b0; cfg_data = $urandom;
		size_reg = sz; frame_fill = 0; spectrum_ready = 0;
	endtask

	task automatic load_random_frame(input int count);
		for (int i = 0; i < count; i++) load_sample($urandom);
	endtask

	// Reads before any transform, at the reset size
	task automatic test_reads_before_done();
		read_word(0); read_word(1023); read_word(511);
	endtask

	// Full-length frame at the largest size with extreme samples
	task automatic test_full_size_frame();
		for (int i = 0; i < 1024; i++) begin
			case (i % 4)
				0: load_sample(16'sh7fff);
				1: load_sample(-16'sh8000);
				default: load_sample($urandom);
			endcase
		end
		read_word(0); read_word(512); read_word(513); read_word(1023);
		for (int i = 0; i < 6; i++) read_word($urandom_range(1023));
	endtask

	// Size zero acts as one; large sizes clamp to the maximum
	task automatic test_size_limits();
		settle_and_set_size(4'd0);
		load_sample(16'sh7fff); load_sample(-16'sh8000);
		read_word(0); read_word(1); read_word(2); read_word(1023);
		settle_and_set_size(4'd15);
		read_word(1023); read_word(0);
		settle_and_set_size(4'd1);
		load_sample(-16'sh8000); load_sample(-16'sh8000);
		read_word(0); read_word(1);
	endtask

	// Register write drops a part-loaded frame; first load of a frame clears done
	task automatic test_frame_restart();
		settle_and_set_size(4'd3);
		load_random_frame(8);
		read_word(7);
		load_sample($urandom);
		read_word(0);
		load_random_frame(3);
		settle_and_set_size(4'd3);
		read_word(0);
		load_random_frame(8);
		read_word(3);
	endtask

	// Receiver holds off while reads keep coming, then sender waits for all results
	task automatic test_back_pressure();
		hold_off_cycles = 400;
		for (int i = 0; i < 24; i++) read_word($urandom_range(7));
		wait_drained();
		for (int i = 0; i < 4; i++) read_word(i);
	endtask

	// Random frames at mostly small sizes with reads mixed in
	task automatic test_random_traffic(input int budget);
		int sent, n, cnt;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0) settle_and_set_size($urandom_range(0, 15));
			else if ($urandom_range(4) == 0) settle_and_set_size($urandom_range(1, 5));
			n = 1 << points_log2();
			cnt = ($urandom_range(4) == 0) ? $urandom_range(1, n) : n;
			if (n > 64 && $urandom_range(3) != 0) cnt = $urandom_range(1, 8);
			// keep the item count near the budget
			if (cnt > budget - sent + 1) cnt = budget - sent + 1;
			for (int i = 0; i < cnt; i++) begin
				if ($urandom_range(7) == 0) read_word($urandom_range(1023));
				else load_sample($urandom);
				sent++;
			end
			for (int i = 0; i < $urandom_range(2, 10); i++) begin
				if ($urandom_range(3) == 0) read_word($urandom_range(1023));
				else read_word($urandom_range(n - 1));
				sent++;
			end
		end
	endtask

	// Receiver stall pattern
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_gap_pct);
	end

	// Compare each delivered word with the oldest prediction
	always @(posedge clk) begin
		spectrum_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (spectrum_q.size() == 0) begin
				$display("%0t: unexpected word idx=%0d value=%0d", $time, result_index, value);
				errors++;
			end else begin
				e = spectrum_q.pop_front();
				if (value !== e.value || result_index !== e.index || last !== e.last ||
				    ready_res !== e.ready) begin
					$display("%0t: mismatch exp v=%0d i=%0d l=%0b r=%0b got v=%0d i=%0d l=%0b r=%0b",
						$time, e.value, e.index, e.last, e.ready,
						value, result_index, last, ready_res);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		errors = 0; quiet_cycles = 0; hold_off_cycles = 0;
		send_gap_pct = 8; recv_gap_pct = 82;
		in_valid = 1'b0; kind = 1'b0; sample = '0; word_index = '0;
		out_stall = 1'b0; cfg_we = 1'b0; cfg_data = '0;
		size_reg = 4'd10; frame_fill = 0; spectrum_ready = 0;
		for (int i = 0; i < rfft_pkg::MAX_POINTS; i++) fft_words[i] = 0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reads_before_done();
		test_full_size_frame();
		test_size_limits();
		test_frame_restart();
		test_back_pressure();
		test_random_traffic(200);
		send_gap_pct = 82; recv_gap_pct = 8;
		test_random_traffic(200);
		send_gap_pct = 0; recv_gap_pct = 0;
		test_random_traffic(200);

		wait_drained();
		repeat (4 * (1 << points_log2()) * points_log2() + 50) @(negedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule

@@ real_fft_in_place.f @@
src/rfft_pkg.sv
src/rfft_ram.sv
src/rfft_seq.sv
src/real_fft_in_place.sv
tb/real_fft_in_place_tb.sv
